[rtl/irpd_pkg.sv]
// Shared types and constants for the infrared pulse-distance frame receiver.
package irpd_pkg;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_LEAD_LOW  = 3'd1,
		PH_LEAD_HIGH = 3'd2,
		PH_FIRST_LOW = 3'd3,
		PH_DATA      = 3'd4,
		PH_DONE      = 3'd5
	} phase_t;

	localparam int unsigned REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_LEADER_LOW_MIN  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LEADER_LOW_MAX  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LEADER_HIGH_MIN = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LEADER_HIGH_MAX = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BIT_LOW_MAX     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BIT_HIGH_MAX    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH_MIN    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH_MAX   = 3'd7;

	localparam logic [7:0] RST_LEADER_LOW_MIN  = 8'd15;
	localparam logic [7:0] RST_LEADER_LOW_MAX  = 8'd25;
	localparam logic [7:0] RST_LEADER_HIGH_MIN = 8'd35;
	localparam logic [7:0] RST_LEADER_HIGH_MAX = 8'd45;
	localparam logic [7:0] RST_BIT_LOW_MAX     = 8'd4;
	localparam logic [7:0] RST_BIT_HIGH_MAX    = 8'd8;
	localparam logic [7:0] RST_ONE_HIGH_MIN    = 8'd7;
	localparam logic [7:0] RST_ZERO_HIGH_MAX   = 8'd3;

	// shortest high that can count as a zero
	localparam logic [7:0] ZERO_HIGH_MIN = 8'd2;

	typedef struct packed {
		logic [7:0] leader_low_min;
		logic [7:0] leader_low_max;
		logic [7:0] leader_high_min;
		logic [7:0] leader_high_max;
		logic [7:0] bit_low_max;
		logic [7:0] bit_high_max;
		logic [7:0] one_high_min;
		logic [7:0] zero_high_max;
	} cfg_t;

	typedef struct packed {
		logic       checksum_ok;
		logic [7:0] data_byte3;
		logic [7:0] data_byte2;
		logic [7:0] data_byte1;
		logic [7:0] data_byte0;
		logic [7:0] start_byte;
	} result_t;

endpackage

[rtl/irpd_core.sv]
// Leader check, bit classification and frame assembly for the IR receiver.
module irpd_core #(
	parameter int unsigned FRAME_BYTES = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              level,
	input  irpd_pkg::cfg_t    cfg,
	output logic              emit,
	output irpd_pkg::result_t result
);

	localparam int unsigned BYTE_W = $clog2(FRAME_BYTES + 1);
	localparam int unsigned IDX_W  = $clog2(FRAME_BYTES);
	localparam logic [BYTE_W-1:0] LAST_BYTE = BYTE_W'(FRAME_BYTES - 1);

	irpd_pkg::phase_t phase_q, phase_n;

	logic [7:0]        low_q, low_n;
	logic [7:0]        high_q, high_n;
	logic              taken_q, taken_n;
	logic [3:0]        bit_q, bit_n;
	logic [BYTE_W-1:0] byte_q, byte_n;
	logic [7:0]        shift_q, shift_n;
	logic [7:0]        sum_q, sum_n;
	logic [7:0]        store_q [FRAME_BYTES];

	logic       low;
	logic [7:0] low_inc, high_inc;
	logic       is_one, is_zero, bit_ok;
	logic       data_abort, byte_done, frame_done;
	logic       store_we;

	assign low      = !level;
	assign low_inc  = (low_q == 8'hFF) ? low_q : low_q + 8'd1;
	assign high_inc = (high_q == 8'hFF) ? high_q : high_q + 8'd1;

	assign is_one  = high_q >= cfg.one_high_min;
	assign is_zero = (high_q >= irpd_pkg::ZERO_HIGH_MIN) && (high_q <= cfg.zero_high_max);
	assign bit_ok  = is_one || is_zero;

	// low sample in a data bit: too long a low, or an unclassifiable high
	assign data_abort = (low_inc > cfg.bit_low_max) || (!taken_q && !bit_ok);
	assign byte_done  = !taken_q && bit_ok && (bit_q == 4'd7) && !data_abort;
	assign frame_done = byte_done && (byte_q == LAST_BYTE);

	// next state
	always_comb begin
		phase_n = phase_q;
		unique case (phase_q)
			irpd_pkg::PH_LEAD_LOW: begin
				if (low) begin
					if (low_inc > cfg.leader_low_max)
						phase_n = irpd_pkg::PH_IDLE;
				end else begin
					phase_n = (low_q < cfg.leader_low_min) ? irpd_pkg::PH_IDLE
					                                       : irpd_pkg::PH_LEAD_HIGH;
				end
			end
			irpd_pkg::PH_LEAD_HIGH: begin
				if (low) begin
					phase_n = (high_q < cfg.leader_high_min) ? irpd_pkg::PH_IDLE
					                                         : irpd_pkg::PH_FIRST_LOW;
				end else if (high_inc > cfg.leader_high_max) begin
					phase_n = irpd_pkg::PH_IDLE;
				end
			end
			irpd_pkg::PH_FIRST_LOW: begin
				if (!low)
					phase_n = irpd_pkg::PH_DATA;
			end
			irpd_pkg::PH_DATA: begin
				if (!low) begin
					if (high_inc > cfg.bit_high_max)
						phase_n = irpd_pkg::PH_IDLE;
				end else if (data_abort) begin
					phase_n = irpd_pkg::PH_IDLE;
				end else if (frame_done) begin
					phase_n = irpd_pkg::PH_DONE;
				end
			end
			irpd_pkg::PH_DONE: phase_n = irpd_pkg::PH_IDLE;
			default: begin
				phase_n = low ? irpd_pkg::PH_LEAD_LOW : irpd_pkg::PH_IDLE;
			end
		endcase
	end

	// datapath updates
	always_comb begin
		low_n    = low_q;
		high_n   = high_q;
		taken_n  = taken_q;
		bit_n    = bit_q;
		byte_n   = byte_q;
		shift_n  = shift_q;
		sum_n    = sum_q;
		store_we = 1'b0;
		emit     = 1'b0;
		unique case (phase_q)
			irpd_pkg::PH_LEAD_LOW: begin
				if (low)
					low_n = low_inc;
			end
			irpd_pkg::PH_LEAD_HIGH: begin
				if (low) begin
					if (high_q >= cfg.leader_high_min) begin
						taken_n = 1'b0;
						bit_n   = 4'd0;
						byte_n  = '0;
						low_n   = 8'd1;
						high_n  = 8'd0;
						sum_n   = 8'd0;
					end
				end else begin
					high_n = high_inc;
				end
			end
			irpd_pkg::PH_FIRST_LOW: begin
				if (low)
					low_n = low_inc;
				else
					high_n = 8'd1;
			end
			irpd_pkg::PH_DATA: begin
				if (!low) begin
					high_n  = high_inc;
					taken_n = 1'b0;
					low_n   = 8'd0;
				end else begin
					low_n  = low_inc;
					high_n = 8'd0;
					if (!taken_q && bit_ok) begin
						shift_n = {is_one, shift_q[7:1]};
						taken_n = 1'b1;
						bit_n   = bit_q + 4'd1;
					end
					if (byte_done) begin
						bit_n    = 4'd0;
						byte_n   = byte_q + BYTE_W'(1);
						store_we = step;
						emit     = step && frame_done;
						if ((byte_q != '0) && (byte_q != LAST_BYTE))
							sum_n = sum_q + shift_n;
					end
				end
			end
			irpd_pkg::PH_DONE: ;
			default: begin
				if (low) begin
					low_n  = 8'd0;
					high_n = 8'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= irpd_pkg::PH_IDLE;
			low_q   <= 8'd0;
			high_q  <= 8'd0;
			taken_q <= 1'b0;
			bit_q   <= 4'd0;
			byte_q  <= '0;
			shift_q <= 8'd0;
			sum_q   <= 8'd0;
		end else if (step) begin
			phase_q <= phase_n;
			low_q   <= low_n;
			high_q  <= high_n;
			taken_q <= taken_n;
			bit_q   <= bit_n;
			byte_q  <= byte_n;
			shift_q <= shift_n;
			sum_q   <= sum_n;
		end
	end

	always_ff @(posedge clk) begin
		if (store_we)
			store_q[byte_q[IDX_W-1:0]] <= shift_n;
	end

	// all bytes but the last are already stored when the frame completes
	assign result.start_byte  = store_q[0];
	assign result.checksum_ok = (sum_q == shift_n);

	logic [7:0] data_bytes [4];

	for (genvar k = 0; k < 4; k++) begin : g_data
		if (k + 1 < FRAME_BYTES - 1) begin : g_real
			assign data_bytes[k] = store_q[k+1];
		end else begin : g_none
			assign data_bytes[k] = 8'd0;
		end
	end

	assign result.data_byte0 = data_bytes[0];
	assign result.data_byte1 = data_bytes[1];
	assign result.data_byte2 = data_bytes[2];
	assign result.data_byte3 = data_bytes[3];

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == irpd_pkg::PH_DONE) && step |=> phase_q == irpd_pkg::PH_IDLE)
		else $error("done phase did not return to idle");

	a_emit_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (phase_q == irpd_pkg::PH_DATA) && low && step)
		else $error("result raised outside a data low sample");

	a_emit_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> phase_q == irpd_pkg::PH_DONE)
		else $error("frame completion did not enter done phase");

endmodule

[rtl/ir_pulse_distance_frame_receiver_unit.sv]
// Top level of the IR pulse-distance frame receiver: config, core and result buffer.
// Throughput: one line sample per clock cycle while s_tready is high.
// A completed result is registered into the result buffer in the cycle after the frame's final sample.
// A two-entry result buffer takes the output; s_tready drops only while two results wait.
// Reset clears the decoder state and buffer and loads the register reset values;
// the frame byte store is not cleared.
module ir_pulse_distance_frame_receiver_unit #(
	parameter int unsigned FRAME_BYTES = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] line_level, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // start_byte, data_byte0..data_byte3
	output logic        m_tuser,   // checksum_ok
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	irpd_pkg::cfg_t    cfg_q;
	irpd_pkg::result_t res;
	irpd_pkg::result_t e0_q, e1_q;
	logic              emit, step, pop;
	logic [1:0]        cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_low_min  <= irpd_pkg::RST_LEADER_LOW_MIN;
			cfg_q.leader_low_max  <= irpd_pkg::RST_LEADER_LOW_MAX;
			cfg_q.leader_high_min <= irpd_pkg::RST_LEADER_HIGH_MIN;
			cfg_q.leader_high_max <= irpd_pkg::RST_LEADER_HIGH_MAX;
			cfg_q.bit_low_max     <= irpd_pkg::RST_BIT_LOW_MAX;
			cfg_q.bit_high_max    <= irpd_pkg::RST_BIT_HIGH_MAX;
			cfg_q.one_high_min    <= irpd_pkg::RST_ONE_HIGH_MIN;
			cfg_q.zero_high_max   <= irpd_pkg::RST_ZERO_HIGH_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				irpd_pkg::REG_LEADER_LOW_MIN:  cfg_q.leader_low_min  <= cfg_data;
				irpd_pkg::REG_LEADER_LOW_MAX:  cfg_q.leader_low_max  <= cfg_data;
				irpd_pkg::REG_LEADER_HIGH_MIN: cfg_q.leader_high_min <= cfg_data;
				irpd_pkg::REG_LEADER_HIGH_MAX: cfg_q.leader_high_max <= cfg_data;
				irpd_pkg::REG_BIT_LOW_MAX:     cfg_q.bit_low_max     <= cfg_data;
				irpd_pkg::REG_BIT_HIGH_MAX:    cfg_q.bit_high_max    <= cfg_data;
				irpd_pkg::REG_ONE_HIGH_MIN:    cfg_q.one_high_min    <= cfg_data;
				irpd_pkg::REG_ZERO_HIGH_MAX:   cfg_q.zero_high_max   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign step = s_tvalid && s_tready;

	irpd_core #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.level  (s_tdata[0]),
		.cfg    (cfg_q),
		.emit   (emit),
		.result (res)
	);

	// two-entry result queue, head in e0_q
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != 2'd0;
	assign s_tready = cnt_q != 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else if (emit && !pop)
			cnt_q <= cnt_q + 2'd1;
		else if (pop && !emit)
			cnt_q <= cnt_q - 2'd1;
	end

	always_ff @(posedge clk) begin
		if ((cnt_q == 2'd0 && emit) || (cnt_q == 2'd1 && emit && pop))
			e0_q <= res;
		else if (cnt_q == 2'd2 && pop)
			e0_q <= e1_q;
		if (cnt_q == 2'd1 && emit && !pop)
			e1_q <= res;
	end

	assign m_tdata = {e0_q.data_byte3, e0_q.data_byte2, e0_q.data_byte1,
	                  e0_q.data_byte0, e0_q.start_byte};
	assign m_tuser = e0_q.checksum_ok;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue overfilled");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	a_emit_visible: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> m_tvalid)
		else $error("completed frame not presented");

endmodule

[tb/sv/irpd_frame_checker.sv]
`timescale 1ns / 100ps
// Checker for the IR frame receiver: follows the line samples, predicts frames and compares them.
module irpd_frame_checker #(
	parameter int unsigned FRAME_BYTES = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          errors,
	output int          pending,
	output int          decoded,
	output int          samples
);
	import irpd_pkg::*;

	cfg_t        regs;
	phase_t      phase;
	logic [7:0]  low_cnt;
	logic [7:0]  high_cnt;
	logic        bit_done;
	logic [3:0]  bit_cnt;
	int unsigned byte_cnt;
	logic [7:0]  shifter;
	logic [7:0]  frame_bytes [FRAME_BYTES];
	result_t     frames_due [$];

	initial begin
		errors  = 0;
		pending = 0;
		decoded = 0;
		samples = 0;
	end

	function automatic logic [7:0] bump(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	task automatic mismatch(input string what, input logic [39:0] got, input logic [39:0] want);
		$display("%0t checker: %s mismatch, got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	task automatic follow_line(input logic lvl);
		logic       is_low;
		logic       quit;
		result_t    r;
		logic [7:0] sum;
		logic [7:0] dbyte [4];
		int         k;
		is_low = !lvl;
		quit = 1'b0;
		case (phase)
			PH_LEAD_LOW: begin
				if (is_low) begin
					low_cnt = bump(low_cnt);
					if (low_cnt > regs.leader_low_max)
						phase = PH_IDLE;
				end else begin
					phase = (low_cnt < regs.leader_low_min) ? PH_IDLE : PH_LEAD_HIGH;
				end
			end
			PH_LEAD_HIGH: begin
				if (is_low) begin
					if (high_cnt < regs.leader_high_min) begin
						phase = PH_IDLE;
					end else begin
						phase = PH_FIRST_LOW;
						bit_done = 1'b0;
						bit_cnt = '0;
						byte_cnt = 0;
						low_cnt = 8'd1;
						high_cnt = '0;
					end
				end else begin
					high_cnt = bump(high_cnt);
					if (high_cnt > regs.leader_high_max)
						phase = PH_IDLE;
				end
			end
			PH_FIRST_LOW: begin
				if (is_low) begin
					low_cnt = bump(low_cnt);
				end else begin
					high_cnt = 8'd1;
					phase = PH_DATA;
				end
			end
			PH_DATA: begin
				if (!is_low) begin
					high_cnt = bump(high_cnt);
					if (high_cnt > regs.bit_high_max)
						phase = PH_IDLE;
					bit_done = 1'b0;
					low_cnt = '0;
				end else begin
					low_cnt = bump(low_cnt);
					if (low_cnt > regs.bit_low_max)
						quit = 1'b1;
					if (!bit_done) begin
						if (high_cnt >= regs.one_high_min) begin
							shifter = {1'b1, shifter[7:1]};
							bit_done = 1'b1;
							bit_cnt = bit_cnt + 4'd1;
						end else if (high_cnt >= ZERO_HIGH_MIN && high_cnt <= regs.zero_high_max) begin
							shifter = {1'b0, shifter[7:1]};
							bit_done = 1'b1;
							bit_cnt = bit_cnt + 4'd1;
						end else begin
							quit = 1'b1;
						end
					end
					high_cnt = '0;
					// an abort beats a byte store in the same sample
					if (quit) begin
						phase = PH_IDLE;
					end else if (bit_cnt >= 4'd8) begin
						bit_cnt = '0;
						if (byte_cnt < FRAME_BYTES)
							frame_bytes[byte_cnt] = shifter;
						byte_cnt++;
						if (byte_cnt >= FRAME_BYTES) begin
							phase = PH_DONE;
							sum = '0;
							for (k = 0; k < 4; k++)
								dbyte[k] = (k + 1 < FRAME_BYTES - 1) ? frame_bytes[k + 1] : 8'h00;
							for (k = 1; k < FRAME_BYTES - 1; k++)
								sum = sum + frame_bytes[k];
							r.start_byte  = frame_bytes[0];
							r.data_byte0  = dbyte[0];
							r.data_byte1  = dbyte[1];
							r.data_byte2  = dbyte[2];
							r.data_byte3  = dbyte[3];
							r.checksum_ok = (sum == frame_bytes[FRAME_BYTES - 1]);
							frames_due.push_back(r);
						end
					end
				end
			end
			PH_DONE: begin
				phase = PH_IDLE;
			end
			default: begin
				phase = PH_IDLE;
				if (is_low) begin
					low_cnt = '0;
					high_cnt = '0;
					phase = PH_LEAD_LOW;
				end
			end
		endcase
	endtask

	task automatic check_frame();
		result_t want;
		if (frames_due.size() == 0) begin
			mismatch("unexpected result", m_tdata, '0);
			return;
		end
		want = frames_due.pop_front();
		if (m_tdata[7:0] != want.start_byte)
			mismatch("start_byte", m_tdata[7:0], want.start_byte);
		if (m_tdata[15:8] != want.data_byte0)
			mismatch("data_byte0", m_tdata[15:8], want.data_byte0);
		if (m_tdata[23:16] != want.data_byte1)
			mismatch("data_byte1", m_tdata[23:16], want.data_byte1);
		if (m_tdata[31:24] != want.data_byte2)
			mismatch("data_byte2", m_tdata[31:24], want.data_byte2);
		if (m_tdata[39:32] != want.data_byte3)
			mismatch("data_byte3", m_tdata[39:32], want.data_byte3);
		if (m_tuser != want.checksum_ok)
			mismatch("checksum_ok", m_tuser, want.checksum_ok);
		decoded++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = {RST_LEADER_LOW_MIN, RST_LEADER_LOW_MAX, RST_LEADER_HIGH_MIN,
				RST_LEADER_HIGH_MAX, RST_BIT_LOW_MAX, RST_BIT_HIGH_MAX,
				RST_ONE_HIGH_MIN, RST_ZERO_HIGH_MAX};
			phase = PH_IDLE;
			low_cnt = '0;
			high_cnt = '0;
			bit_done = 1'b0;
			bit_cnt = '0;
			byte_cnt = 0;
			shifter = '0;
			frames_due.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LEADER_LOW_MIN:  regs.leader_low_min  = cfg_data;
					REG_LEADER_LOW_MAX:  regs.leader_low_max  = cfg_data;
					REG_LEADER_HIGH_MIN: regs.leader_high_min = cfg_data;
					REG_LEADER_HIGH_MAX: regs.leader_high_max = cfg_data;
					REG_BIT_LOW_MAX:     regs.bit_low_max     = cfg_data;
					REG_BIT_HIGH_MAX:    regs.bit_high_max    = cfg_data;
					REG_ONE_HIGH_MIN:    regs.one_high_min    = cfg_data;
					REG_ZERO_HIGH_MAX:   regs.zero_high_max   = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_frame();
			if (s_tvalid && s_tready) begin
				follow_line(s_tdata[0]);
				samples++;
			end
			pending = frames_due.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Testbench top for the IR frame receiver: clock, reset, line and register stimulus, verdict.
module tb_top;
	import irpd_pkg::*;

	localparam int unsigned FRAME_BYTES = 6;
	localparam int FRAME_BITS  = 8 * FRAME_BYTES;
	localparam int HOLD_CYCLES = 1500;

	typedef enum int {
		FL_NONE,
		FL_NARROW_HIGH,
		FL_WIDE_HIGH,
		FL_LONG_LOW,
		FL_CUT,
		FL_LEAD_LOW_SHORT,
		FL_LEAD_HIGH_LONG,
		FL_SLOW_START
	} flaw_e;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [7:0]  s_tdata   = '0;
	logic        m_tready  = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data  = '0;
	logic        s_tready;
	logic        m_tvalid;
	logic [39:0] m_tdata;
	logic        m_tuser;

	int   errors;
	int   pending;
	int   decoded;
	int   samples;
	int   frames_sent   = 0;
	int   settings_done = 0;
	bit   src_gaps      = 1'b1;
	bit   sink_gaps     = 1'b1;
	bit   hold_req      = 1'b0;
	cfg_t cur;

	ir_pulse_distance_frame_receiver_unit #(
		.FRAME_BYTES(FRAME_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	irpd_frame_checker #(
		.FRAME_BYTES(FRAME_BYTES)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending),
		.decoded(decoded),
		.samples(samples)
	);

	initial forever #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(99, 0);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic int pick(input int lo, input int hi);
		if (hi <= lo)
			return lo;
		return $urandom_range(hi, lo);
	endfunction

	function automatic int least(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	function automatic int flush_len();
		int n;
		n = cur.leader_high_max + cur.bit_high_max + 4;
		return (n > 80) ? 80 : n;
	endfunction

	function automatic logic [8*FRAME_BYTES-1:0] make_payload(input bit good_sum);
		logic [8*FRAME_BYTES-1:0] p;
		logic [7:0]               sum;
		int                       i;
		sum = '0;
		for (i = 0; i < FRAME_BYTES; i++)
			p[8*i +: 8] = $urandom_range(255, 0);
		for (i = 1; i < FRAME_BYTES - 1; i++)
			sum = sum + p[8*i +: 8];
		if (good_sum)
			p[8*(FRAME_BYTES-1) +: 8] = sum;
		return p;
	endfunction

	function automatic cfg_t rand_cfg();
		cfg_t c;
		c.leader_low_min  = $urandom_range(6, 0);
		c.leader_low_max  = c.leader_low_min + $urandom_range(4, 0);
		c.leader_high_min = $urandom_range(6, 0);
		c.leader_high_max = c.leader_high_min + $urandom_range(4, 0);
		c.bit_low_max     = $urandom_range(4, 1);
		c.one_high_min    = $urandom_range(6, 3);
		c.bit_high_max    = c.one_high_min + $urandom_range(3, 0);
		c.zero_high_max   = ($urandom_range(3, 0) == 0) ? 8'hFF :
			$urandom_range(c.one_high_min - 1, ZERO_HIGH_MIN);
		return c;
	endfunction

	// one line sample, with a random gap in front of it
	task automatic send_sample(input logic lvl);
		int n;
		n = src_gaps ? gap_len() : 0;
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, lvl};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_run(input logic lvl, input int n);
		repeat (n) send_sample(lvl);
	endtask

	task automatic send_noise(input int runs);
		repeat (runs) send_run($urandom_range(1, 0), $urandom_range(12, 1));
	endtask

	// sender waits until every expected frame is out, then for the output latency
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_regs(input cfg_t c);
		logic [REG_IDX_W-1:0] idx [8];
		logic [7:0]           val [8];
		int                   i;
		idx = '{REG_LEADER_LOW_MIN, REG_LEADER_LOW_MAX, REG_LEADER_HIGH_MIN,
			REG_LEADER_HIGH_MAX, REG_BIT_LOW_MAX, REG_BIT_HIGH_MAX,
			REG_ONE_HIGH_MIN, REG_ZERO_HIGH_MAX};
		val = '{c.leader_low_min, c.leader_low_max, c.leader_high_min,
			c.leader_high_max, c.bit_low_max, c.bit_high_max,
			c.one_high_min, c.zero_high_max};
		for (i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		cur = c;
		settings_done++;
	endtask

	task automatic send_frame(input logic [8*FRAME_BYTES-1:0] payload, input flaw_e flaw,
		input int at);
		int lo_n;
		int hi_n;
		int k;
		int lows;
		int zmax;
		int b;
		frames_sent++;
		lo_n = pick(cur.leader_low_min, least(cur.leader_low_max, cur.leader_low_min + 5));
		if (flaw == FL_LEAD_LOW_SHORT)
			lo_n = (cur.leader_low_min > 0) ? cur.leader_low_min - 1 : 0;
		send_run(1'b0, lo_n + 1);
		hi_n = pick(cur.leader_high_min, least(cur.leader_high_max, cur.leader_high_min + 5));
		if (flaw == FL_LEAD_HIGH_LONG)
			hi_n = cur.leader_high_max + 1;
		send_run(1'b1, hi_n + 1);
		// long first low saturates its counter but must not abort
		send_run(1'b0, (flaw == FL_SLOW_START) ? 300 : pick(1, 3));
		zmax = least(least(cur.zero_high_max, cur.bit_high_max), cur.one_high_min - 1);
		for (b = 0; b < FRAME_BITS && !(flaw == FL_CUT && b == at); b++) begin
			k = payload[b] ? pick(cur.one_high_min, least(cur.bit_high_max, cur.one_high_min + 3)) :
				pick(ZERO_HIGH_MIN, zmax);
			if (flaw == FL_NARROW_HIGH && b == at)
				k = 1;
			if (flaw == FL_WIDE_HIGH && b == at)
				k = cur.bit_high_max + 1;
			send_run(1'b1, k);
			lows = (b == FRAME_BITS - 1) ? 1 : pick(1, least(cur.bit_low_max, 3));
			if (flaw == FL_LONG_LOW && b == at)
				lows = cur.bit_low_max + 1;
			send_run(1'b0, lows);
		end
		send_run(1'b1, (flaw == FL_NONE || flaw == FL_SLOW_START) ? pick(1, 3) : flush_len());
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(99, 0);
		if (r < 70) begin
			send_frame(make_payload($urandom_range(9, 0) != 0), FL_NONE, 0);
		end else if (r < 88) begin
			send_frame(make_payload(1'b1), flaw_e'($urandom_range(FL_LEAD_HIGH_LONG, FL_NARROW_HIGH)),
				$urandom_range(FRAME_BITS - 1, 0));
		end else begin
			send_noise($urandom_range(8, 1));
			send_run(1'b1, flush_len());
		end
	endtask

	// result side: random stalls, or one long counted hold-off on request
	initial begin
		int n;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else begin
				n = sink_gaps ? gap_len() : 0;
				if (n > 0) begin
					m_tready <= 1'b0;
					repeat (n - 1) @(negedge clk);
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	initial begin
		logic [8*FRAME_BYTES-1:0] bad;
		int                       round;
		int                       guard;
		cur = {RST_LEADER_LOW_MIN, RST_LEADER_LOW_MAX, RST_LEADER_HIGH_MIN, RST_LEADER_HIGH_MAX,
			RST_BIT_LOW_MAX, RST_BIT_HIGH_MAX, RST_ONE_HIGH_MIN, RST_ZERO_HIGH_MAX};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset timings
		send_run(1'b1, 3);
		send_frame('0, FL_NONE, 0);
		send_frame('1, FL_NONE, 0);
		send_frame(make_payload(1'b1), FL_NONE, 0);
		bad = make_payload(1'b1);
		bad[8*(FRAME_BYTES-1)] = ~bad[8*(FRAME_BYTES-1)];
		send_frame(bad, FL_NONE, 0);
		send_frame(make_payload(1'b1), FL_NARROW_HIGH, 7);
		send_frame(make_payload(1'b1), FL_WIDE_HIGH, 20);
		send_frame(make_payload(1'b1), FL_LONG_LOW, 31);
		send_frame(make_payload(1'b1), FL_CUT, 12);
		send_frame(make_payload(1'b1), FL_LEAD_LOW_SHORT, 0);
		send_frame(make_payload(1'b1), FL_LEAD_HIGH_LONG, 0);
		send_frame(make_payload(1'b1), FL_SLOW_START, 0);

		// wide but usable limits
		drain();
		write_regs({8'd0, 8'd255, 8'd1, 8'd8, 8'd255, 8'd8, 8'd5, 8'd255});
		send_run(1'b1, flush_len());
		send_frame(make_payload(1'b1), FL_NONE, 0);
		send_frame(make_payload(1'b1), FL_NARROW_HIGH, 40);
		send_frame(make_payload(1'b1), FL_SLOW_START, 0);

		// all limits at 255: counters saturate and wait
		drain();
		write_regs({8{8'hFF}});
		send_run(1'b0, 300);
		send_run(1'b1, 300);
		send_noise(10);

		// all limits at zero
		drain();
		write_regs('0);
		send_noise(20);

		for (round = 0; round < 4; round++) begin
			drain();
			write_regs(rand_cfg());
			src_gaps  = (round != 0);
			sink_gaps = (round != 0);
			send_run(1'b1, flush_len());
			repeat (10) random_item();
			if (round == 1) begin
				// output held off long enough for the buffer to fill and the input to stall
				src_gaps = 1'b0;
				hold_req = 1'b1;
				repeat (4) send_frame(make_payload(1'b1), FL_NONE, 0);
				src_gaps = 1'b1;
			end
			if (round == 2)
				drain();
		end

		guard = 0;
		while (decoded < 50 && guard < 200) begin
			random_item();
			guard++;
		end

		drain();
		repeat (10) @(negedge clk);
		$display("tb_top: %0d line samples taken, %0d frames offered, %0d results checked",
			samples, frames_sent, decoded);
		$display("tb_top: %0d register settings incl. all-zero and all-255, with output hold-off",
			settings_done);
		if (errors == 0 && pending == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

[files.f]
rtl/irpd_pkg.sv
rtl/irpd_core.sv
rtl/ir_pulse_distance_frame_receiver_unit.sv
tb/sv/irpd_frame_checker.sv
tb/sv/tb_top.sv
